FILE: src/assert_macros.svh
// Assertion helpers for the stencil block.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define HDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HDS_ASSERT_IMP(label, ante, cons, msg)
`define HDS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: src/hds_pkg.sv
package hds_pkg;

  // Grid and sample geometry
  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_COLS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int DIM_BITS    = 8;
  localparam int COEFF_BITS  = 15;

  // Stencil arithmetic widths
  localparam int LAP_BITS    = SAMPLE_BITS + 3;
  localparam int PROD_BITS   = COEFF_BITS + 1 + LAP_BITS;
  localparam int DELTA_BITS  = PROD_BITS - 16;
  localparam int SUM_BITS    = DELTA_BITS + 1;

  localparam logic [DIM_BITS-1:0] DIM_MIN  = DIM_BITS'(3);
  localparam logic [DIM_BITS-1:0] COLS_MAX = DIM_BITS'(MAX_COLS);
  localparam logic [DIM_BITS-1:0] ROWS_MAX = DIM_BITS'(MAX_ROWS);

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_DIFF_COEFF = 2'd2
  } reg_idx_t;

  // One column entry of the line store: last row and the row above it
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] prev_val;
    logic [SAMPLE_BITS-1:0] prev2_val;
  } pair_t;

  // Five-point neighborhood handed to the stencil datapath
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] u;
    logic [SAMPLE_BITS-1:0] up;
    logic [SAMPLE_BITS-1:0] dn;
    logic [SAMPLE_BITS-1:0] lf;
    logic [SAMPLE_BITS-1:0] rt;
  } stencil_in_t;

  // Per-request bookkeeping that rides along the pipeline
  typedef struct packed {
    logic                emit_cell;
    logic                emit_border;
    logic                interior;
    logic                border_last;
    logic [ROW_BITS-1:0] cell_row;
    logic [ROW_BITS-1:0] border_row;
    logic [COL_BITS-1:0] col;
  } meta_t;

  // Clamp a size register into 3..max
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (r < DIM_MIN) r = DIM_MIN;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

FILE: src/hds_cell.sv
// One column cell of the sliding window; takes its neighbor's column on a shift
module hds_cell (
  input  logic          clk,
  input  logic          shift,
  input  hds_pkg::pair_t pair_in,
  output hds_pkg::pair_t pair
);

  always_ff @(posedge clk) begin
    if (shift) begin
      pair <= pair_in;
    end
  end

endmodule

FILE: src/hds_line_store.sv
// Two line stores kept side by side as one word per column
module hds_line_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [hds_pkg::COL_BITS-1:0] wr_addr,
  input  hds_pkg::pair_t               wr_data,
  input  logic                         rd_en,
  input  logic [hds_pkg::COL_BITS-1:0] rd_addr,
  output hds_pkg::pair_t               rd_data
);

  hds_pkg::pair_t mem [hds_pkg::MAX_COLS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/hds_stencil.sv
// Stencil datapath: Laplacian times coefficient registered, then round,
// add and saturate.
module hds_stencil (
  input  logic                              clk,
  input  logic                              load,
  input  hds_pkg::stencil_in_t              nbr,
  input  logic [hds_pkg::COEFF_BITS-1:0]    coeff,
  output logic [hds_pkg::SAMPLE_BITS-1:0]   value
);

  logic        [hds_pkg::LAP_BITS-1:0]   side_sum;
  logic        [hds_pkg::LAP_BITS-1:0]   center4;
  logic signed [hds_pkg::LAP_BITS-1:0]   lap;
  logic signed [hds_pkg::PROD_BITS-1:0]  coeff_ext;
  logic signed [hds_pkg::PROD_BITS-1:0]  lap_ext;
  logic signed [hds_pkg::PROD_BITS-1:0]  prod_full;
  logic signed [hds_pkg::PROD_BITS-1:0]  prod;
  logic        [hds_pkg::SAMPLE_BITS-1:0] u_q;
  logic signed [hds_pkg::PROD_BITS-1:0]  biased;
  logic signed [hds_pkg::DELTA_BITS-1:0] delta;
  logic signed [hds_pkg::SUM_BITS-1:0]   sum;

  // up + down + left + right - 4u, always fits one guard bit past the sum
  assign side_sum = hds_pkg::LAP_BITS'(nbr.up) + hds_pkg::LAP_BITS'(nbr.dn)
                  + hds_pkg::LAP_BITS'(nbr.lf) + hds_pkg::LAP_BITS'(nbr.rt);
  assign center4  = {1'b0, nbr.u, 2'b00};
  assign lap      = $signed(side_sum - center4);

  // both operands widened to the full product width before the multiply
  assign coeff_ext = $signed({{(hds_pkg::PROD_BITS-hds_pkg::COEFF_BITS){1'b0}}, coeff});
  assign lap_ext   = $signed({{(hds_pkg::PROD_BITS-hds_pkg::LAP_BITS){lap[hds_pkg::LAP_BITS-1]}},
                              lap});
  assign prod_full = coeff_ext * lap_ext;

  // product stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_full;
      u_q  <= nbr.u;
    end
  end

  // round half up (floor after bias), add center, clamp to sample range
  assign biased = prod + hds_pkg::PROD_BITS'(32768);
  assign delta  = biased[hds_pkg::PROD_BITS-1:16];
  assign sum    = $signed({{(hds_pkg::SUM_BITS-hds_pkg::SAMPLE_BITS){1'b0}}, u_q})
                + $signed({delta[hds_pkg::DELTA_BITS-1], delta});

  always_comb begin
    if (sum < 0) begin
      value = '0;
    end else if (sum > $signed(hds_pkg::SUM_BITS'({hds_pkg::SAMPLE_BITS{1'b1}}))) begin
      value = '1;
    end else begin
      value = sum[hds_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: src/heat_diffusion_stencil_step.sv
// Channel   Dir  Handshake                    Payload
// sample    in   sample_valid / sample_stall  sample[15:0]
// result    out  result_valid / result_stall  new_sample[15:0], out_row, out_col, last
// config    in   APB, psel&penable&pwrite     grid_rows, grid_cols, diffusion_coeff
//
// One request per clock while sample_stall is low; row 0 gives no result,
// rows 1..R-2 give one each. The last row gives two results per request, and
// the output register holds both before it takes the next. A request passes
// the window, multiply and round/saturate into the output register stages.
// rst is synchronous; it clears raster counters and valids, not the line stores.
// A result stall backs up and raises sample_stall once every stage is full.
`include "assert_macros.svh"

module heat_diffusion_stencil_step (
  input  logic                             clk,
  input  logic                             rst,
  // sample channel
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [hds_pkg::SAMPLE_BITS-1:0]  sample,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [hds_pkg::SAMPLE_BITS-1:0]  new_sample,
  output logic [hds_pkg::ROW_BITS-1:0]     out_row,
  output logic [hds_pkg::COL_BITS-1:0]     out_col,
  output logic                             last,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int RB = hds_pkg::ROW_BITS;
  localparam int CB = hds_pkg::COL_BITS;
  localparam int DB = hds_pkg::DIM_BITS;

  // configuration registers
  logic [DB-1:0]                  grid_rows;
  logic [DB-1:0]                  grid_cols;
  logic [hds_pkg::COEFF_BITS-1:0] diffusion_coeff;
  logic                           cfg_wr;
  hds_pkg::reg_idx_t              cfg_idx;
  logic                           size_wr;

  // raster position
  logic [RB-1:0] row_count;
  logic [CB-1:0] col_count;
  logic [RB-1:0] row_count_next;
  logic [CB-1:0] col_count_next;
  logic [DB-1:0] rows_used;
  logic [DB-1:0] cols_used;
  logic [RB-1:0] r_eff;
  logic [CB-1:0] c_eff;
  logic [DB-1:0] c_plus1;
  logic [DB-1:0] c_plus2;
  logic [DB-1:0] r_plus1;
  logic [DB-1:0] nn_col;

  // handshake and pipeline control
  logic accept;
  logic v1;
  logic v2;
  logic adv1;
  logic adv2;
  logic out_free;
  logic consumed;

  // window and line store
  hds_pkg::pair_t      rd_pair;
  hds_pkg::pair_t      cur_pair;
  hds_pkg::pair_t      left_pair;
  hds_pkg::pair_t      wr_pair;
  hds_pkg::stencil_in_t nbr_next;
  hds_pkg::stencil_in_t nbr;
  hds_pkg::meta_t      meta_next;
  hds_pkg::meta_t      meta1;
  hds_pkg::meta_t      meta2;
  logic [hds_pkg::SAMPLE_BITS-1:0] sten_val;

  // output register: stencil result and optional border result
  logic                            have_cell;
  logic                            have_border;
  logic [hds_pkg::SAMPLE_BITS-1:0] cell_val;
  logic [RB-1:0]                   cell_row;
  logic [RB-1:0]                   border_row;
  logic [CB-1:0]                   res_col;
  logic                            border_last;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = hds_pkg::reg_idx_t'(paddr[3:2]);
  assign size_wr = cfg_wr &
                   (cfg_idx == hds_pkg::REG_GRID_ROWS || cfg_idx == hds_pkg::REG_GRID_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= DB'(101);
      grid_cols       <= DB'(101);
      diffusion_coeff <= hds_pkg::COEFF_BITS'(16384);
    end else if (cfg_wr) begin
      case (cfg_idx)
        hds_pkg::REG_GRID_ROWS:  grid_rows       <= pwdata[DB-1:0];
        hds_pkg::REG_GRID_COLS:  grid_cols       <= pwdata[DB-1:0];
        hds_pkg::REG_DIFF_COEFF: diffusion_coeff <= pwdata[hds_pkg::COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hds_pkg::REG_GRID_ROWS:  prdata = 32'(grid_rows);
      hds_pkg::REG_GRID_COLS:  prdata = 32'(grid_cols);
      hds_pkg::REG_DIFF_COEFF: prdata = 32'(diffusion_coeff);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- raster counters ----------------
  assign rows_used = hds_pkg::clamp_dim(grid_rows, hds_pkg::ROWS_MAX);
  assign cols_used = hds_pkg::clamp_dim(grid_cols, hds_pkg::COLS_MAX);

  always_comb begin
    if ({1'b0, row_count} >= rows_used || {1'b0, col_count} >= cols_used) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_count;
      c_eff = col_count;
    end
  end

  assign c_plus1 = {1'b0, c_eff} + DB'(1);
  assign c_plus2 = {1'b0, c_eff} + DB'(2);
  assign r_plus1 = {1'b0, r_eff} + DB'(1);
  // column two requests ahead, for the line store prefetch
  assign nn_col  = (c_plus2 >= cols_used) ? c_plus2 - cols_used : c_plus2;

  always_comb begin
    row_count_next = r_eff;
    col_count_next = c_plus1[CB-1:0];
    if (c_plus1 >= cols_used) begin
      col_count_next = '0;
      row_count_next = (r_plus1 >= rows_used) ? '0 : r_plus1[RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // ---------------- window chain and line store ----------------
  // rd_pair holds column c+1, cur_pair column c, left_pair column c-1
  hds_line_store u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c_eff),
    .wr_data (wr_pair),
    .rd_en   (accept),
    .rd_addr (nn_col[CB-1:0]),
    .rd_data (rd_pair)
  );

  hds_cell u_cell_cur (
    .clk     (clk),
    .shift   (accept),
    .pair_in (rd_pair),
    .pair    (cur_pair)
  );

  hds_cell u_cell_left (
    .clk     (clk),
    .shift   (accept),
    .pair_in (cur_pair),
    .pair    (left_pair)
  );

  // column c moves down one row in the store
  assign wr_pair.prev_val  = sample;
  assign wr_pair.prev2_val = cur_pair.prev_val;

  assign nbr_next.u  = cur_pair.prev_val;
  assign nbr_next.up = cur_pair.prev2_val;
  assign nbr_next.dn = sample;
  assign nbr_next.lf = left_pair.prev_val;
  assign nbr_next.rt = rd_pair.prev_val;

  // what this request produces
  assign meta_next.emit_cell   = (r_eff != '0);
  assign meta_next.emit_border = (r_plus1 >= rows_used);
  assign meta_next.interior    = ({1'b0, r_eff} >= DB'(2)) && (c_eff != '0) &&
                                 (c_plus1 < cols_used);
  assign meta_next.border_last = (c_plus1 >= cols_used);
  assign meta_next.cell_row    = r_eff - RB'(1);
  assign meta_next.border_row  = r_eff;
  assign meta_next.col         = c_eff;

  // ---------------- pipeline control ----------------
  assign consumed     = result_valid & ~result_stall;
  assign out_free     = ~(have_cell | have_border) | (consumed & ~(have_cell & have_border));
  assign adv2         = v2 & out_free;
  assign adv1         = v1 & (~v2 | out_free);
  assign sample_stall = v1 & v2 & ~out_free;
  assign accept       = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
    end
  end

  // neighborhood stage
  always_ff @(posedge clk) begin
    if (accept) begin
      nbr   <= nbr_next;
      meta1 <= meta_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      meta2 <= meta1;
    end
  end

  hds_stencil u_stencil (
    .clk   (clk),
    .load  (adv1),
    .nbr   (nbr),
    .coeff (diffusion_coeff),
    .value (sten_val)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      have_cell   <= 1'b0;
      have_border <= 1'b0;
    end else begin
      if (consumed) begin
        if (have_cell) begin
          have_cell <= 1'b0;
        end else begin
          have_border <= 1'b0;
        end
      end
      if (adv2) begin
        have_cell   <= meta2.emit_cell;
        have_border <= meta2.emit_border;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      cell_val    <= meta2.interior ? sten_val : '0;
      cell_row    <= meta2.cell_row;
      border_row  <= meta2.border_row;
      res_col     <= meta2.col;
      border_last <= meta2.border_last;
    end
  end

  assign result_valid = have_cell | have_border;
  assign new_sample   = have_cell ? cell_val : '0;
  assign out_row      = have_cell ? cell_row : border_row;
  assign out_col      = res_col;
  assign last         = ~have_cell & border_last;

  // ---------------- assertions ----------------
  `HDS_ASSERT_IMP(a_pos_in_range, 1'b1,
    ({1'b0, row_count} < rows_used) && ({1'b0, col_count} < cols_used),
    "raster position outside the grid")
  `HDS_ASSERT_IMP(a_stall_only_full, sample_stall, v1 && v2,
    "input stalled with a free pipeline stage")
  `HDS_ASSERT_IMP(a_last_corner, result_valid && last,
    ({1'b0, out_row} == rows_used - DB'(1)) && ({1'b0, out_col} == cols_used - DB'(1)),
    "last flag away from the final grid cell")
  `HDS_ASSERT_NXT(a_border_kept, result_valid && result_stall && have_border,
    have_border, "pending border result lost under stall")

endmodule
